// File: hdl/i32bf16_pkg.sv
// Package for the int32 x bfloat16 multiply core.
// Holds field widths, bfloat16 encodings and shared types; no dependencies.
`default_nettype none
package i32bf16_pkg;

  localparam int ActW    = 32;
  localparam int WgtW    = 16;
  localparam int ResW    = 16;
  localparam int SigW    = 8;
  localparam int ProdW   = 48;   // (magnitude * significand) << 8
  localparam int ExpW    = 9;    // biased exponent before clamping, up to 286
  localparam int ShW     = 6;    // normalize shift, 0..32
  localparam int InDataW = 48;
  localparam int OutDataW = 16;

  localparam logic [ExpW-1:0] ExpOffset = 9'd32;
  localparam logic [ExpW-1:0] ExpMax    = 9'd255;
  localparam logic [7:0]      ExpAllOne = 8'hFF;
  localparam logic [5:0]      TopBit    = 6'd47;

  localparam logic [ResW-1:0] BfQnan   = 16'hFFC0;
  localparam logic [ResW-1:0] BfPosInf = 16'h7F80;
  localparam logic [ResW-1:0] BfNegInf = 16'hFF80;
  localparam logic [ResW-1:0] BfPosZro = 16'h0000;
  localparam logic [ResW-1:0] BfNegZro = 16'h8000;

  typedef struct packed {
    logic            special;   // result fixed by operand class
    logic [ResW-1:0] spec_val;
    logic            sign;
    logic [ExpW-1:0] exp0;      // exponent when the leading one sits at bit 47
    logic [ProdW-1:0] prod;
  } mul_stage_t;

endpackage
`default_nettype wire

// File: hdl/int32_times_bf16_multiply_core.sv
// Top level: signed int32 times bfloat16 weight, bfloat16 product.
// Depends on i32bf16_pkg (widths, encodings, stage struct).
`default_nettype none
//
//  channel | dir | payload                                    | transfer when
//  --------+-----+--------------------------------------------+---------------------
//  in_     | in  | tdata[31:0] act_value, [47:32] weight_bits | in_tvalid & in_tready
//  out_    | out | tdata[15:0] result_bits                    | out_tvalid & out_tready
//
//  Two register stages: stage 1 holds the 32x8 significand product and the
//  operand classification, stage 2 (output register) holds the normalized,
//  rounded result. One transfer per cycle sustained while out_tready stays high.
//  Each stage loads when it is empty or its successor takes its item, so
//  stalls back up one stage at a time and bubbles get squeezed out.
//  rst_n (synchronous) clears the stage valid flags only.
//
module int32_times_bf16_multiply_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [i32bf16_pkg::InDataW-1:0] in_tdata,   // [31:0] act_value, [47:32] weight_bits
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [i32bf16_pkg::OutDataW-1:0]     out_tdata   // [15:0] result_bits
);
  import i32bf16_pkg::*;

  // ---------------- stage 1: classify, normalize weight, multiply ----------
  logic [ActW-1:0]  act;
  logic [WgtW-1:0]  wgt;
  logic [7:0]       w_exp;
  logic [6:0]       w_man;
  logic             a_neg;
  logic             sign;
  logic [2:0]       w_lz;       // leading zeros of a subnormal fraction
  logic [SigW-1:0]  sig;
  logic [ExpW-1:0]  exp0;
  logic [ActW-1:0]  mag;
  logic [ActW+SigW-1:0] prod_raw;
  mul_stage_t       s1_nxt, s1_r;
  logic             v1_r, v2_r;
  logic             ld1, ld2;

  assign act   = in_tdata[ActW-1:0];
  assign wgt   = in_tdata[ActW +: WgtW];
  assign w_exp = wgt[14:7];
  assign w_man = wgt[6:0];
  assign a_neg = act[ActW-1];
  assign sign  = a_neg ^ wgt[15];

  always_comb begin
    w_lz = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (w_man[i]) begin
        w_lz = 3'(6 - i);
      end
    end
  end

  always_comb begin
    if (w_exp == 8'd0) begin
      sig  = SigW'({w_man, 1'b0} << w_lz);
      exp0 = ExpOffset - ExpW'(w_lz);
    end else begin
      sig  = {1'b1, w_man};
      exp0 = ExpW'(w_exp) + ExpOffset;
    end
  end

  assign mag      = a_neg ? (~act + 1'b1) : act;
  assign prod_raw = (ActW+SigW)'(mag) * (ActW+SigW)'(sig);

  always_comb begin
    s1_nxt.sign     = sign;
    s1_nxt.exp0     = exp0;
    s1_nxt.prod     = {prod_raw, 8'd0};
    s1_nxt.special  = 1'b1;
    s1_nxt.spec_val = BfQnan;
    if (w_exp == ExpAllOne && w_man != 7'd0) begin
      s1_nxt.spec_val = BfQnan;
    end else if (w_exp == ExpAllOne && act == '0) begin
      s1_nxt.spec_val = BfQnan;
    end else if (w_exp == ExpAllOne) begin
      s1_nxt.spec_val = sign ? BfNegInf : BfPosInf;
    end else if (act == '0 || wgt[14:0] == 15'd0) begin
      s1_nxt.spec_val = sign ? BfNegZro : BfPosZro;
    end else begin
      s1_nxt.special = 1'b0;
    end
  end

  // handshake: a stage loads when empty or draining
  assign ld2       = !v2_r || out_tready;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- stage 2: leading-one search, round, pack ---------------
  logic [5:0]       lead;
  logic [5:0]       lead_gap;
  logic [ShW-1:0]   sh_amt;
  logic [ExpW-1:0]  e_pre;
  logic [ProdW-1:0] sh;
  logic [7:0]       e_fin;
  logic [6:0]       frac;
  logic [ResW-1:0]  res_nxt, res_r;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < ProdW; i++) begin
      if (s1_r.prod[i]) begin
        lead = 6'(i);
      end
    end
  end

  // search stops at the leading one or when the exponent reaches zero
  assign lead_gap = TopBit - lead;
  assign sh_amt   = (ExpW'(lead_gap) < s1_r.exp0) ? lead_gap : s1_r.exp0[ShW-1:0];
  assign e_pre    = s1_r.exp0 - ExpW'(sh_amt);
  assign sh       = s1_r.prod << sh_amt;

  always_comb begin
    e_fin = e_pre[7:0];
    frac  = 7'd0;
    if (e_pre >= ExpMax) begin
      e_fin = ExpAllOne;
    end else if (e_pre == '0) begin
      // subnormal: fraction sits one bit higher
      if (sh[47:40] == 8'hFF) begin
        e_fin = 8'd1;
      end else begin
        frac = sh[47:41] + 7'(sh[40]);
      end
    end else begin
      if (sh[46:39] == 8'hFF) begin
        e_fin = e_pre[7:0] + 8'd1;
      end else begin
        frac = sh[46:40] + 7'(sh[39]);
      end
    end
  end

  assign res_nxt = s1_r.special ? s1_r.spec_val : {s1_r.sign, e_fin, frac};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = res_r;

endmodule
`default_nettype wire

// File: sim/int32_times_bf16_multiply_checker.sv
// Checker for the int32 x bfloat16 multiply core: watches both streams,
// predicts each product and compares. Depends on i32bf16_pkg.
`timescale 1ns / 100ps
module int32_times_bf16_multiply_checker
  import i32bf16_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  output int                  fail_count,
  output int                  pending_count
);

  logic [ResW-1:0] expected_products[$];

  function automatic logic [ResW-1:0] bf16_product(logic [ActW-1:0] act, logic [WgtW-1:0] wgt);
    logic         sgn;
    logic [7:0]   w_exp;
    logic [6:0]   w_man;
    logic [7:0]   sig;
    logic [6:0]   t;
    int           e;
    int           pos;
    logic [31:0]  mag;
    logic [63:0]  prod;
    logic [7:0]   frac;
    sgn   = act[31] ^ wgt[15];
    w_exp = wgt[14:7];
    w_man = wgt[6:0];
    if (w_exp == 8'hFF && w_man != 0) return BfQnan;
    if (w_exp == 8'hFF && act == 0) return BfQnan;
    if (w_exp == 8'hFF) return sgn ? BfNegInf : BfPosInf;
    if (act == 0 || wgt[14:0] == 0) return sgn ? BfNegZro : BfPosZro;
    e = w_exp;
    if (w_exp == 0) begin
      t = w_man;
      while (!t[6]) begin
        t = t << 1;
        e--;
      end
      sig = {t, 1'b0};
    end else begin
      sig = {1'b1, w_man};
    end
    mag  = act[31] ? -act : act;
    prod = (64'(mag) * 64'(sig)) << 8;
    pos  = 47;
    e    = e + 32;
    while (!prod[pos] && pos > 15 && e > 0) begin
      pos--;
      e--;
    end
    frac = 0;
    if (e >= 255) begin
      e = 255;
    end else if (e == 0) begin
      if (((prod >> (pos - 7)) & 64'hFF) == 64'hFF) e = 1;
      else frac = 8'((prod >> (pos - 6)) & 64'h7F) + 8'((prod >> (pos - 7)) & 64'h1);
    end else begin
      if (((prod >> (pos - 8)) & 64'hFF) == 64'hFF) e = e + 1;
      else frac = 8'((prod >> (pos - 7)) & 64'h7F) + 8'((prod >> (pos - 8)) & 64'h1);
    end
    return {sgn, 8'(e), frac[6:0]};
  endfunction

  assign pending_count = expected_products.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else if (out_tdata !== expected_products[0]) begin
          $display("%0t: result_bits expected %h actual %h", $time,
                   expected_products[0], out_tdata);
          fail_count <= fail_count + 1;
          void'(expected_products.pop_front());
        end else begin
          void'(expected_products.pop_front());
        end
      end
      if (in_tvalid && in_tready)
        expected_products.push_back(bf16_product(in_tdata[31:0], in_tdata[47:32]));
    end
  end

endmodule

// File: sim/int32_times_bf16_multiply_core_test.sv
// Testbench top for int32_times_bf16_multiply_core: drives operand transfers
// with random idling and back-pressure; the checker does the predicting.
`timescale 1ns / 100ps
module int32_times_bf16_multiply_core_test;
  import i32bf16_pkg::*;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_tvalid = 0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 0;
  logic [OutDataW-1:0] out_tdata;
  int                  fail_count;
  int                  pending_count;
  bit                  calm = 0;        // no idling on either side
  bit                  hold_sink = 0;   // long receiver hold-off

  int unsigned stall_cycles;

  always #2 clk = ~clk;

  int32_times_bf16_multiply_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  int32_times_bf16_multiply_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: ~14% stall, none while calm, forced low while held
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_sink) out_tready <= 0;
    else out_tready <= calm || ($urandom_range(99) >= 14);
  end

  // random operands, weighted toward interesting classes
  function automatic logic [InDataW-1:0] rand_operands();
    logic [31:0] a;
    logic [15:0] w;
    case ($urandom_range(9))
      0: a = 32'h8000_0000;
      1: a = '0;
      2: a = $urandom_range(255) - 128;
      3: a = 32'h7FFF_FFFF;
      default: a = $urandom;
    endcase
    w = 16'($urandom);
    case ($urandom_range(9))
      0: w[14:7] = 8'h00;
      1: w[14:7] = 8'hFF;
      2: w[14:7] = 8'(200 + $urandom_range(54));
      3: w[14:0] = '0;
      default: ;
    endcase
    return {w, a};
  endfunction

  // offer one transfer; valid stays high back to back, drops only on idle
  task automatic send(logic [InDataW-1:0] d);
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  logic [31:0] dir_act[12] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h3, 32'h0, 32'h5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFF};
  logic [15:0] dir_wgt[12] = '{16'h7F80, 16'h7FC1, 16'hFF80, 16'h0000,
    16'h8000, 16'h0001, 16'h3F80, 16'h7F7F, 16'hFF7F, 16'h0040, 16'h807F, 16'h4000};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send({dir_wgt[i], dir_act[i]});
    // sender pause until drained
    go_idle();
    while (pending_count != 0) @(posedge clk);
    // receiver hold-off while the sender keeps offering
    hold_sink = 1;
    fork
      begin
        for (stall_cycles = 0; stall_cycles < 40; stall_cycles++) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 20; i++) send(rand_operands());
    join
    for (int i = 0; i < 870; i++) begin
      calm = (i >= 300 && i < 420);
      send(rand_operands());
    end
    calm = 0;
    go_idle();
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
